// ===== rtl/slt_pkg.sv =====
// Shared constants and codes for the sorted list table.
// No dependencies; imported by the top level.
`default_nettype none

package slt_pkg;

  // Table size and derived widths
  localparam int unsigned ENTRIES = 16;
  localparam int unsigned IDX_W   = $clog2(ENTRIES);
  localparam int unsigned LINK_W  = $clog2(ENTRIES + 1);

  // Fixed field widths of the beats
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned PAY_W   = 64;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned CNT_W   = 5;

  // The null link is the value ENTRIES
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(ENTRIES);

  typedef enum logic {
    MODE_INSERT = 1'b0,
    MODE_SEARCH = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_FULL      = 2'd1,
    ST_FOUND     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

endpackage

`default_nettype wire

// ===== rtl/sorted_list_table_with_free_chain.sv =====
// Top level of the sorted list table: walk sequencer, link valid bits and RAMs.
// Depends on slt_pkg and slt_ram.
`default_nettype none

// A table of ENTRIES slots (16), each with a signed key, a 64-bit payload and
// a link, kept in three one-port-read RAMs. Used slots form one list in
// ascending key order; unused slots form a free chain. An insert takes the
// free-chain head and links it in before the first entry whose key is not
// smaller (so a new key goes before equal keys); a search returns the first equal
// key. Each input beat gives exactly one result beat. One item is processed
// at a time: the walk reads one list entry per cycle from the RAMs. An insert
// reads the free-chain successor, walks to the first key that is not smaller,
// writes the new entry and, when it follows an existing entry, rewrites the
// predecessor's link; a search walks to the first equal key or the list end.
// Either walk visits at most ENTRIES entries. The next input beat is taken
// while the previous result still waits at the output. The link RAM needs no
// clearing pass after reset: a per-slot valid bit makes an unwritten link
// read as its reset value, the following slot.
module sorted_list_table_with_free_chain
  import slt_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic                    mode_i,
  input  wire logic signed [KEY_W-1:0] key_i,
  input  wire logic        [PAY_W-1:0] payload_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic             [1:0]       status_o,
  output logic             [POS_W-1:0] position_o,
  output logic             [PAY_W-1:0] found_payload_o,
  output logic             [CNT_W-1:0] entry_count_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FREE,
    S_WALK,
    S_LINK,
    S_LINK2,
    S_DONE
  } state_e;

  state_e                    state_q;
  mode_e                     mode_q;
  logic signed [KEY_W-1:0]   key_q;
  logic        [PAY_W-1:0]   pay_q;
  logic        [LINK_W-1:0]  list_head_q;
  logic        [LINK_W-1:0]  free_head_q;
  logic        [LINK_W-1:0]  used_q;
  logic        [LINK_W-1:0]  slot_q;
  logic        [LINK_W-1:0]  nfree_q;
  logic        [LINK_W-1:0]  prev_q;
  logic        [LINK_W-1:0]  cur_q;
  logic        [LINK_W-1:0]  steps_q;
  logic        [IDX_W-1:0]   rd_idx_q;
  logic        [ENTRIES-1:0] lvalid_q;
  status_e                   res_status_q;
  logic        [LINK_W-1:0]  res_pos_q;
  logic        [PAY_W-1:0]   res_pay_q;

  // RAM ports
  logic                     rd_en;
  logic        [IDX_W-1:0]  rd_addr;
  logic signed [KEY_W-1:0]  key_rdata;
  logic        [PAY_W-1:0]  pay_rdata;
  logic        [LINK_W-1:0] link_rdata;
  logic                     data_we;
  logic                     link_we;
  logic        [IDX_W-1:0]  link_waddr;
  logic        [LINK_W-1:0] link_wdata;

  // Walk helpers
  logic                     accept;
  logic        [LINK_W-1:0] link_eff;
  logic                     link_ok;
  logic        [LINK_W-1:0] steps_n;
  logic                     walk_cont;
  logic                     key_less;
  logic                     key_eq;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);

  // Resolve a link read: slots never written read as their reset link
  assign link_eff  = lvalid_q[rd_idx_q] ? link_rdata
                                        : (LINK_W'(rd_idx_q) + LINK_W'(1));
  assign link_ok   = (link_eff < NULL_LINK);
  assign steps_n   = steps_q + LINK_W'(1);
  assign walk_cont = link_ok && (steps_n < NULL_LINK);
  assign key_less  = (key_rdata < key_q);
  assign key_eq    = (key_rdata == key_q);

  // Read address: free head, list head, or the next link of the walk
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (mode_i == MODE_INSERT) begin
            rd_en   = (free_head_q < NULL_LINK);
            rd_addr = free_head_q[IDX_W-1:0];
          end else begin
            rd_en   = (list_head_q < NULL_LINK);
            rd_addr = list_head_q[IDX_W-1:0];
          end
        end
      end
      S_FREE: begin
        rd_en   = (list_head_q < NULL_LINK);
        rd_addr = list_head_q[IDX_W-1:0];
      end
      S_WALK: begin
        if (!((mode_q == MODE_INSERT) && !key_less) &&
            !((mode_q == MODE_SEARCH) && key_eq)) begin
          rd_en = walk_cont;
        end
        rd_addr = link_eff[IDX_W-1:0];
      end
      default: begin
        rd_en   = 1'b0;
        rd_addr = '0;
      end
    endcase
  end

  // Write ports: new entry first, then the predecessor's link
  always_comb begin
    data_we    = 1'b0;
    link_we    = 1'b0;
    link_waddr = slot_q[IDX_W-1:0];
    link_wdata = cur_q;
    unique case (state_q)
      S_LINK: begin
        data_we = 1'b1;
        link_we = 1'b1;
      end
      S_LINK2: begin
        link_we    = 1'b1;
        link_waddr = prev_q[IDX_W-1:0];
        link_wdata = slot_q;
      end
      default: begin
        data_we = 1'b0;
        link_we = 1'b0;
      end
    endcase
  end

  slt_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (data_we),
    .waddr_i (slot_q[IDX_W-1:0]),
    .wdata_i (key_q),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (key_rdata)
  );

  slt_ram #(.WIDTH(PAY_W), .DEPTH(ENTRIES)) u_pay_ram (
    .clk_i   (clk_i),
    .we_i    (data_we),
    .waddr_i (slot_q[IDX_W-1:0]),
    .wdata_i (pay_q),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (pay_rdata)
  );

  slt_ram #(.WIDTH(LINK_W), .DEPTH(ENTRIES)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (link_rdata)
  );

  // Sequencer, list heads and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      mode_q          <= MODE_INSERT;
      key_q           <= '0;
      pay_q           <= '0;
      list_head_q     <= NULL_LINK;
      free_head_q     <= '0;
      used_q          <= '0;
      slot_q          <= '0;
      nfree_q         <= '0;
      prev_q          <= NULL_LINK;
      cur_q           <= NULL_LINK;
      steps_q         <= '0;
      rd_idx_q        <= '0;
      lvalid_q        <= '0;
      res_status_q    <= ST_INSERTED;
      res_pos_q       <= '0;
      res_pay_q       <= '0;
      out_valid_o     <= 1'b0;
      status_o        <= '0;
      position_o      <= '0;
      found_payload_o <= '0;
      entry_count_o   <= '0;
    end else begin
      // Drop the output beat once taken
      if (out_valid_o && !out_stall_i) begin
        out_valid_o <= 1'b0;
      end
      if (rd_en) begin
        rd_idx_q <= rd_addr;
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            mode_q    <= mode_e'(mode_i);
            key_q     <= key_i;
            pay_q     <= payload_i;
            steps_q   <= '0;
            prev_q    <= NULL_LINK;
            slot_q    <= free_head_q;
            cur_q     <= list_head_q;
            res_pos_q <= '0;
            res_pay_q <= '0;
            if (mode_i == MODE_INSERT) begin
              if (free_head_q < NULL_LINK) begin
                state_q <= S_FREE;
              end else begin
                res_status_q <= ST_FULL;
                state_q      <= S_DONE;
              end
            end else begin
              if (list_head_q < NULL_LINK) begin
                state_q <= S_WALK;
              end else begin
                res_status_q <= ST_NOT_FOUND;
                state_q      <= S_DONE;
              end
            end
          end
        end

        S_FREE: begin
          // Hold the free-chain successor; start the walk at the list head
          nfree_q <= link_eff;
          if (list_head_q < NULL_LINK) begin
            state_q <= S_WALK;
          end else begin
            cur_q   <= NULL_LINK;
            state_q <= S_LINK;
          end
        end

        S_WALK: begin
          if (mode_q == MODE_INSERT) begin
            if (key_less) begin
              // Advance past a smaller key
              prev_q  <= cur_q;
              cur_q   <= link_ok ? link_eff : NULL_LINK;
              steps_q <= steps_n;
              if (!walk_cont) begin
                state_q <= S_LINK;
              end
            end else begin
              state_q <= S_LINK;
            end
          end else begin
            if (key_eq) begin
              res_status_q <= ST_FOUND;
              res_pos_q    <= cur_q;
              res_pay_q    <= pay_rdata;
              state_q      <= S_DONE;
            end else begin
              cur_q   <= link_eff;
              steps_q <= steps_n;
              if (!walk_cont) begin
                res_status_q <= ST_NOT_FOUND;
                state_q      <= S_DONE;
              end
            end
          end
        end

        S_LINK: begin
          // Take the slot off the free chain and hook it into the list
          free_head_q                   <= nfree_q;
          lvalid_q[slot_q[IDX_W-1:0]]   <= 1'b1;
          if (used_q < NULL_LINK) begin
            used_q <= used_q + LINK_W'(1);
          end
          res_status_q <= ST_INSERTED;
          res_pos_q    <= slot_q;
          if (prev_q < NULL_LINK) begin
            state_q <= S_LINK2;
          end else begin
            list_head_q <= slot_q;
            state_q     <= S_DONE;
          end
        end

        S_LINK2: begin
          state_q <= S_DONE;
        end

        S_DONE: begin
          // Load the result beat once the output register is free
          if (!out_valid_o || !out_stall_i) begin
            out_valid_o     <= 1'b1;
            status_o        <= res_status_q;
            position_o      <= POS_W'(res_pos_q);
            found_payload_o <= res_pay_q;
            entry_count_o   <= CNT_W'(used_q);
            state_q         <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/slt_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none

module slt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire
